// File: sv/occupancy_grid_ray_update_assert.svh
// assertion macros for the occupancy grid ray update block
`ifndef OCCUPANCY_GRID_RAY_UPDATE_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_ASSERT_SVH

// condition holds in every cycle out of reset
`define OGR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define OGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ogru_pkg.sv
// ----------------------------------------------------------------------------
// ogru_pkg
// shared types and codes of the occupancy grid ray update block
// ----------------------------------------------------------------------------
package ogru_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COORD_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_INC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OCC_INC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR = 3'd4;

    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_OFF_MAP = 2'd2;

    // classified job from front to back
    typedef struct packed {
        logic                      is_read;
        logic                      skip;
        logic signed [COORD_W:0]   sx;
        logic signed [COORD_W:0]   sy;
        logic signed [COORD_W:0]   ex;
        logic signed [COORD_W:0]   ey;
    } t_job;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_READ,
        S_RMW,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

// File: sv/occupancy_grid_ray_update.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// log-odds occupancy grid updated along bresenham rays
// ----------------------------------------------------------------------------
// channel  | handshake      | payload
// input    | push/full      | i_kind i_start_x i_start_y i_end_x i_end_y
// result   | empty/pop      | o_status o_cell_value o_cells_touched
// config   | i_cfg_we       | i_cfg_idx i_cfg_data
//
// a ray walks each cell on the line through read, modify and write states of the
// grid memory; a read passes through the read and modify states once
// after reset a clearing pass zeroes every word of the grid memory;
// meanwhile up to two transactions wait in the job queue and no result comes
// the job queue holds two items so the front keeps accepting during a walk
module occupancy_grid_ray_update #(
    parameter int MAP_DIM = 256,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_kind,
    input  logic signed [9:0]     i_start_x,
    input  logic signed [9:0]     i_start_y,
    input  logic signed [9:0]     i_end_x,
    input  logic signed [9:0]     i_end_y,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_status,
    output logic signed [15:0]    o_cell_value,
    output logic [8:0]            o_cells_touched,
    input  logic                  i_cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ogru_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ogru_pkg::*;

    localparam int DIM_W = $clog2(MAP_DIM + 1);
    localparam int ADDR_W = 2 * $clog2(MAP_DIM);

    logic [8:0]          r_map_w, r_map_h;
    logic signed [15:0]  r_free, r_occ, r_prior;
    logic [DIM_W-1:0]    w_eff_w, w_eff_h;
    logic                w_job_valid, w_job_take, w_res_valid;
    t_job                w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 9'd256;
            r_map_h <= 9'd256;
            r_free <= -16'sd159;
            r_occ <= 16'sd217;
            r_prior <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAP_WIDTH:  r_map_w <= i_cfg_data[8:0];
                REG_MAP_HEIGHT: r_map_h <= i_cfg_data[8:0];
                REG_FREE_INC:   r_free <= i_cfg_data;
                REG_OCC_INC:    r_occ <= i_cfg_data;
                REG_PRIOR:      r_prior <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff_w = ({{(DIM_W+9){1'b0}}, r_map_w} > (DIM_W+18)'(MAP_DIM)) ?
                     DIM_W'(MAP_DIM) : DIM_W'(r_map_w);
    assign w_eff_h = ({{(DIM_W+9){1'b0}}, r_map_h} > (DIM_W+18)'(MAP_DIM)) ?
                     DIM_W'(MAP_DIM) : DIM_W'(r_map_h);

    ogru_front #(.DIM_W(DIM_W), .QDEPTH_W(1)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full), .i_kind(i_kind),
        .i_sx(i_start_x), .i_sy(i_start_y), .i_ex(i_end_x), .i_ey(i_end_y),
        .i_eff_w(w_eff_w), .i_eff_h(w_eff_h),
        .o_job_valid(w_job_valid), .o_job(w_job), .i_job_take(w_job_take)
    );

    ogru_back #(.DIM_W(DIM_W), .ADDR_W(ADDR_W), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid), .i_job(w_job), .o_job_take(w_job_take),
        .i_eff_w(w_eff_w), .i_free_inc(r_free), .i_occ_inc(r_occ), .i_prior(r_prior),
        .o_res_valid(w_res_valid), .i_res_take(pop),
        .o_status(o_status), .o_value(o_cell_value), .o_touched(o_cells_touched)
    );

    assign empty = !w_res_valid;

endmodule

// File: sv/ogru_front.sv
// ----------------------------------------------------------------------------
// ogru_front
// accepts transactions, checks cells against the map and queues jobs
// ----------------------------------------------------------------------------
`include "occupancy_grid_ray_update_assert.svh"
module ogru_front #(
    parameter int DIM_W = 9,
    parameter int QDEPTH_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_kind,
    input  logic signed [9:0]             i_sx,
    input  logic signed [9:0]             i_sy,
    input  logic signed [9:0]             i_ex,
    input  logic signed [9:0]             i_ey,
    input  logic [DIM_W-1:0]              i_eff_w,
    input  logic [DIM_W-1:0]              i_eff_h,
    output logic                          o_job_valid,
    output ogru_pkg::t_job                o_job,
    input  logic                          i_job_take
);
    import ogru_pkg::*;

    localparam int QD = 1 << QDEPTH_W;
    localparam int CMP_W = (DIM_W > 9) ? DIM_W + 1 : 10;

    t_job                r_q [QD];
    logic [QDEPTH_W-1:0] r_wp, r_rp;
    logic [QDEPTH_W:0]   r_cnt;
    logic                w_push, w_pop;
    logic                w_s_on, w_e_on;
    t_job                w_job;

    function automatic logic on_map(input logic signed [9:0] x, input logic signed [9:0] y,
                                    input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        logic ok;
        ok = !x[9] && !y[9];
        if (CMP_W'(x[8:0]) >= CMP_W'(w)) ok = 1'b0;
        if (CMP_W'(y[8:0]) >= CMP_W'(h)) ok = 1'b0;
        return ok;
    endfunction

    assign w_s_on = on_map(i_sx, i_sy, i_eff_w, i_eff_h);
    assign w_e_on = on_map(i_ex, i_ey, i_eff_w, i_eff_h);

    always_comb begin
        w_job.is_read = i_kind;
        w_job.skip = i_kind ? !w_s_on : !(w_s_on && w_e_on);
        w_job.sx = {i_sx[9], i_sx};
        w_job.sy = {i_sy[9], i_sy};
        w_job.ex = {i_ex[9], i_ex};
        w_job.ey = {i_ey[9], i_ey};
    end

    assign o_full = (r_cnt == (QDEPTH_W+1)'(QD));
    assign w_push = i_push && !o_full;
    assign o_job_valid = (r_cnt != '0);
    assign w_pop = o_job_valid && i_job_take;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QDEPTH_W+1)'(w_push) - (QDEPTH_W+1)'(w_pop);
        end
    end

    `OGR_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= (QDEPTH_W+1)'(QD),
        "job queue overfilled")
    `OGR_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, o_full && !i_job_take, o_full,
        "full dropped without a pop")
    `OGR_ASSERT_ALWAYS(a_ptr_sync, i_clk, i_rst_n,
        (r_cnt == '0 || r_cnt == (QDEPTH_W+1)'(QD)) ? (r_wp == r_rp) : (r_wp != r_rp),
        "queue pointers disagree with count")

endmodule

// File: sv/ogru_back.sv
// ----------------------------------------------------------------------------
// ogru_back
// clears the grid after reset, walks the line and updates the grid memory one cell at a time, serves reads
// ----------------------------------------------------------------------------
`include "occupancy_grid_ray_update_assert.svh"
module ogru_back #(
    parameter int DIM_W = 9,
    parameter int ADDR_W = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  ogru_pkg::t_job                i_job,
    output logic                          o_job_take,
    input  logic [DIM_W-1:0]              i_eff_w,
    input  logic signed [15:0]            i_free_inc,
    input  logic signed [15:0]            i_occ_inc,
    input  logic signed [15:0]            i_prior,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output logic [1:0]                    o_status,
    output logic signed [15:0]            o_value,
    output logic [8:0]                    o_touched
);
    import ogru_pkg::*;

    localparam int MEM_D = 1 << ADDR_W;
    localparam int SW = ((VALUE_WIDTH > 16) ? VALUE_WIDTH : 16) + 2;
    localparam int CW = 12;

    logic signed [VALUE_WIDTH-1:0] r_mem [MEM_D];
    logic signed [VALUE_WIDTH-1:0] r_rd;

    t_state r_st, n_st;
    logic [ADDR_W:0]       r_clr;
    t_job                  r_job;
    logic signed [CW-1:0]  r_cx, r_cy, r_mx, r_my, r_nx, r_ny;
    logic signed [CW-1:0]  r_d, r_maj2, r_min2;
    logic [CW-1:0]         r_i, r_major;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_last;
    logic                  r_res_valid;
    logic [1:0]            r_status;
    logic signed [15:0]    r_value;
    logic [8:0]            r_touched;

    logic signed [CW-1:0]  w_dx, w_dy, w_adx, w_ady;
    logic [2*CW-1:0]       w_addr_full;
    logic signed [SW-1:0]  w_sum, w_rsum;
    logic signed [VALUE_WIDTH-1:0] w_wdata;
    logic                  w_mem_we;
    logic [ADDR_W-1:0]     w_mem_wa;

    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VALUE_WIDTH-1)) - 1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    assign w_dx = CW'(r_job.ex) - CW'(r_job.sx);
    assign w_dy = CW'(r_job.ey) - CW'(r_job.sy);
    assign w_adx = w_dx < 0 ? -w_dx : w_dx;
    assign w_ady = w_dy < 0 ? -w_dy : w_dy;
    assign w_addr_full = r_cy[CW-1:0] * {{(CW-DIM_W){1'b0}}, i_eff_w} + r_cx[CW-1:0];

    always_comb begin
        w_sum = SW'(r_rd) + SW'(r_last ? i_occ_inc : i_free_inc);
        if (w_sum > VMAX) w_wdata = VALUE_WIDTH'(VMAX);
        else if (w_sum < VMIN) w_wdata = VALUE_WIDTH'(VMIN);
        else w_wdata = VALUE_WIDTH'(w_sum);
        w_rsum = SW'(r_rd) + SW'(i_prior);
    end

    assign w_mem_we = (r_st == S_CLEAR) || (r_st == S_WRITE);
    assign w_mem_wa = (r_st == S_CLEAR) ? r_clr[ADDR_W-1:0] : r_addr;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_wa] <= (r_st == S_CLEAR) ? '0 : w_wdata;
        r_rd <= r_mem[r_addr];
    end

    assign o_job_take = (r_st == S_IDLE) && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_status = r_status;
    assign o_value = r_value;
    assign o_touched = r_touched;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLEAR: if (r_clr == (ADDR_W+1)'(MEM_D - 1)) n_st = S_IDLE;
            S_IDLE:  if (i_job_valid && !r_res_valid) n_st = S_SETUP;
            S_SETUP: begin
                if (r_job.skip) n_st = S_DONE;
                else if (r_job.is_read) n_st = S_READ;
                else n_st = S_READ;
            end
            S_READ:  n_st = S_RMW;
            S_RMW:   n_st = r_job.is_read ? S_DONE : S_WRITE;
            S_WRITE: n_st = r_last ? S_DONE : S_READ;
            S_DONE:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_clr <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_st == S_DONE) r_res_valid <= 1'b1;
            else if (r_res_valid && i_res_take) r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_SETUP: begin
                r_cx <= CW'(r_job.sx);
                r_cy <= CW'(r_job.sy);
                r_i <= '0;
                if (w_adx > w_ady) begin
                    r_major <= w_adx;
                    r_d <= (w_ady <<< 1) - w_adx;
                    r_maj2 <= w_adx <<< 1;
                    r_min2 <= w_ady <<< 1;
                    r_mx <= w_dx > 0 ? CW'(1) : -CW'(1);
                    r_my <= '0;
                    r_nx <= '0;
                    r_ny <= w_dy > 0 ? CW'(1) : -CW'(1);
                    r_last <= !r_job.is_read && (w_adx == 0);
                end else begin
                    r_major <= w_ady;
                    r_d <= (w_adx <<< 1) - w_ady;
                    r_maj2 <= w_ady <<< 1;
                    r_min2 <= w_adx <<< 1;
                    r_mx <= '0;
                    r_my <= w_dy > 0 ? CW'(1) : -CW'(1);
                    r_nx <= w_dx > 0 ? CW'(1) : -CW'(1);
                    r_ny <= '0;
                    r_last <= !r_job.is_read && (w_ady == 0);
                end
            end
            S_READ: begin
                r_addr <= w_addr_full[ADDR_W-1:0];
            end
            S_WRITE: begin
                r_i <= r_i + 1'b1;
                r_last <= (r_i + 1'b1 == r_major);
                if (r_d >= 0) begin
                    r_cx <= r_cx + r_mx + r_nx;
                    r_cy <= r_cy + r_my + r_ny;
                    r_d <= r_d - r_maj2 + r_min2;
                end else begin
                    r_cx <= r_cx + r_mx;
                    r_cy <= r_cy + r_my;
                    r_d <= r_d + r_min2;
                end
            end
            S_DONE: begin
                if (r_job.skip) begin
                    r_status <= ST_OFF_MAP;
                    r_value <= '0;
                    r_touched <= '0;
                end else if (r_job.is_read) begin
                    r_status <= ST_READ;
                    r_touched <= '0;
                    if (w_rsum > SW'(32767)) r_value <= 16'sh7fff;
                    else if (w_rsum < -SW'(32768)) r_value <= -16'sd32768;
                    else r_value <= 16'(w_rsum);
                end else begin
                    r_status <= ST_APPLIED;
                    r_value <= '0;
                    r_touched <= 9'(r_major + 1'b1);
                end
            end
            default: ;
        endcase
    end

    `OGR_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_st == S_DONE, r_res_valid,
        "result not raised after done")
    `OGR_ASSERT_ALWAYS(a_no_take_busy, i_clk, i_rst_n, !(o_job_take && r_st != S_IDLE),
        "job taken while busy")
    `OGR_ASSERT_ALWAYS(a_walk_bound, i_clk, i_rst_n,
        !(r_st == S_WRITE) || (r_i <= r_major), "walk ran past the end cell")

endmodule

// File: verif/occupancy_grid_ray_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_checker
// watches the ray/read and result channels of the occupancy grid block, keeps
// its own log-odds grid and register copy, predicts each result and compares
// ----------------------------------------------------------------------------
package ogru_tb_pkg;

    localparam logic KIND_RAY = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct {
        logic [1:0]         status;
        logic signed [15:0] cell_value;
        logic [8:0]         cells_touched;
    } t_grid_answer;

endpackage

module occupancy_grid_ray_update_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic                  i_kind,
    input  logic signed [9:0]     i_start_x,
    input  logic signed [9:0]     i_start_y,
    input  logic signed [9:0]     i_end_x,
    input  logic signed [9:0]     i_end_y,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic [1:0]            i_status,
    input  logic signed [15:0]    i_cell_value,
    input  logic [8:0]            i_cells_touched,
    input  logic                  i_cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ogru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    import ogru_pkg::*;
    import ogru_tb_pkg::*;

    localparam int GRID_DIM = 256;

    logic signed [15:0] grid_logodds [GRID_DIM*GRID_DIM];
    int map_w, map_h, free_inc, occ_inc, prior;
    t_grid_answer answer_q [$];

    function automatic int clamp16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic bit cell_on_map(int x, int y);
        int w, h;
        w = map_w > GRID_DIM ? GRID_DIM : map_w;
        h = map_h > GRID_DIM ? GRID_DIM : map_h;
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    function automatic void bump_cell(int x, int y, int inc);
        int idx;
        idx = y * (map_w > GRID_DIM ? GRID_DIM : map_w) + x;
        if (idx < GRID_DIM*GRID_DIM)
            grid_logodds[idx] = 16'(clamp16(int'(grid_logodds[idx]) + inc));
    endfunction

    function automatic t_grid_answer update_grid(logic kind, int sx, int sy, int ex, int ey);
        t_grid_answer a;
        int dx, dy, xs, ys, major, minor, mxx, mxy, myx, myy, d, m, cx, cy, idx;
        a.status = ST_OFF_MAP;
        a.cell_value = '0;
        a.cells_touched = '0;
        if (kind == KIND_READ) begin
            if (cell_on_map(sx, sy)) begin
                idx = sy * (map_w > GRID_DIM ? GRID_DIM : map_w) + sx;
                a.status = ST_READ;
                a.cell_value = 16'(clamp16(prior + int'(grid_logodds[idx])));
            end
        end else if (cell_on_map(sx, sy) && cell_on_map(ex, ey)) begin
            dx = ex - sx;
            dy = ey - sy;
            xs = dx > 0 ? 1 : -1;
            ys = dy > 0 ? 1 : -1;
            dx = dx < 0 ? -dx : dx;
            dy = dy < 0 ? -dy : dy;
            if (dx > dy) begin
                major = dx; minor = dy; mxx = xs; mxy = 0; myx = 0; myy = ys;
            end else begin
                major = dy; minor = dx; mxx = 0; mxy = ys; myx = xs; myy = 0;
            end
            d = 2 * minor - major;
            m = 0;
            for (int i = 0; i <= major; i++) begin
                cx = sx + i * mxx + m * myx;
                cy = sy + i * mxy + m * myy;
                if (cell_on_map(cx, cy))
                    bump_cell(cx, cy, i == major ? occ_inc : free_inc);
                if (d >= 0) begin
                    m++;
                    d -= 2 * major;
                end
                d += 2 * minor;
            end
            a.status = ST_APPLIED;
            a.cells_touched = 9'(major + 1);
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: result mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                 want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_grid_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < GRID_DIM*GRID_DIM; i++)
                grid_logodds[i] = '0;
            map_w = 256;
            map_h = 256;
            free_inc = -159;
            occ_inc = 217;
            prior = 0;
            o_fail_count = 0;
            answer_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAP_WIDTH:  map_w = int'(i_cfg_data[8:0]);
                    REG_MAP_HEIGHT: map_h = int'(i_cfg_data[8:0]);
                    REG_FREE_INC:   free_inc = int'($signed(i_cfg_data));
                    REG_OCC_INC:    occ_inc = int'($signed(i_cfg_data));
                    REG_PRIOR:      prior = int'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_cell_value !== want.cell_value)
                        report_mismatch("cell_value", i_cell_value, want.cell_value);
                    if (i_cells_touched !== want.cells_touched)
                        report_mismatch("cells_touched", i_cells_touched, want.cells_touched);
                end
            end
            if (i_push && !i_full)
                answer_q.push_back(update_grid(i_kind, int'(i_start_x), int'(i_start_y),
                                               int'(i_end_x), int'(i_end_y)));
        end
        o_pending = answer_q.size();
    end

endmodule

// File: verif/occupancy_grid_ray_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_tb
// drives rays and cell reads through several grid sizes and increment settings, with random
// push and pop stalls in the first four settings; the checker predicts and compares results
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update_tb;
    import ogru_pkg::*;
    import ogru_tb_pkg::*;

    localparam int IDLE_LIMIT = 300000;
    localparam int NUM_SETTINGS = 7;

    logic i_clk, i_rst_n, push, full, empty, pop;
    logic i_kind;
    logic signed [9:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic [1:0] o_status;
    logic signed [15:0] o_cell_value;
    logic [8:0] o_cells_touched;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int fail_count, pending, idle_cycles;
    int send_idle_pct, recv_idle_pct, eff_w, eff_h;

    int cfg_w [NUM_SETTINGS] = '{256, 17, 256, 511, 0, 1, 40};
    int cfg_h [NUM_SETTINGS] = '{256, 9, 256, 300, 5, 256, 40};
    int cfg_free [NUM_SETTINGS] = '{-159, -32768, 32767, 100, -7, -300, 0};
    int cfg_occ [NUM_SETTINGS] = '{217, 32767, -32768, -50, 9, 4000, 0};
    int cfg_prior [NUM_SETTINGS] = '{0, 32767, -32768, 4660, 0, -1000, 0};
    int item_count [NUM_SETTINGS] = '{180, 200, 220, 200, 40, 200, 300};

    occupancy_grid_ray_update i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_kind(i_kind), .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .empty(empty), .pop(pop),
        .o_status(o_status), .o_cell_value(o_cell_value),
        .o_cells_touched(o_cells_touched), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    occupancy_grid_ray_update_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_kind(i_kind), .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_empty(empty), .i_pop(pop),
        .i_status(o_status), .i_cell_value(o_cell_value),
        .i_cells_touched(o_cells_touched), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop = i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("occupancy_grid_ray_update_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_ray(logic kind, int sx, int sy, int ex, int ey);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        i_kind = kind;
        i_start_x = 10'(sx);
        i_start_y = 10'(sy);
        i_end_x = 10'(ex);
        i_end_y = 10'(ey);
        push = 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = 16'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    function automatic int rand_coord();
        return int'($signed(10'($urandom_range(1023))));
    endfunction

    function automatic int clamp_to(int v, int hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    task automatic send_random();
        int r, sx, sy, ex, ey;
        r = $urandom_range(99);
        if (r < 8 || eff_w == 0 || eff_h == 0) begin
            send_ray(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord());
        end else if (r < 30) begin
            if ($urandom_range(99) < 85)
                send_ray(KIND_READ, $urandom_range(eff_w - 1), $urandom_range(eff_h - 1),
                         rand_coord(), rand_coord());
            else
                send_ray(KIND_READ, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end else begin
            sx = $urandom_range(eff_w - 1);
            sy = $urandom_range(eff_h - 1);
            if (r < 36) begin
                ex = $urandom_range(eff_w - 1);
                ey = $urandom_range(eff_h - 1);
            end else if (r < 40) begin
                ex = rand_coord();
                ey = rand_coord();
            end else begin
                ex = clamp_to(sx + $urandom_range(16) - 8, eff_w - 1);
                ey = clamp_to(sy + $urandom_range(16) - 8, eff_h - 1);
            end
            send_ray(KIND_RAY, sx, sy, ex, ey);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_kind = KIND_RAY;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MAP_WIDTH;
        i_cfg_data = '0;
        send_idle_pct = 26;
        recv_idle_pct = 64;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s == 2) begin
                send_idle_pct = 64;
                recv_idle_pct = 26;
            end else if (s == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            write_reg(REG_MAP_WIDTH, cfg_w[s]);
            write_reg(REG_MAP_HEIGHT, cfg_h[s]);
            write_reg(REG_FREE_INC, cfg_free[s]);
            write_reg(REG_OCC_INC, cfg_occ[s]);
            write_reg(REG_PRIOR, cfg_prior[s]);
            eff_w = cfg_w[s] > 256 ? 256 : cfg_w[s];
            eff_h = cfg_h[s] > 256 ? 256 : cfg_h[s];

            if (s == 0) begin
                send_ray(KIND_READ, 0, 0, 0, 0);
                send_ray(KIND_RAY, 0, 0, 0, 0);
                send_ray(KIND_RAY, 0, 0, 255, 0);
                send_ray(KIND_RAY, 255, 255, 0, 0);
                send_ray(KIND_RAY, 0, 255, 0, 0);
                send_ray(KIND_RAY, 10, 20, 13, 40);
                send_ray(KIND_RAY, 100, 100, 90, 95);
                send_ray(KIND_RAY, 50, 60, 40, 80);
                send_ray(KIND_RAY, -1, 0, 5, 5);
                send_ray(KIND_RAY, 0, 0, 256, 3);
                send_ray(KIND_RAY, 3, 3, 3, -1);
                send_ray(KIND_RAY, -512, -512, 511, 511);
                send_ray(KIND_RAY, 511, 511, -512, -512);
                send_ray(KIND_READ, -1, 5, 0, 0);
                send_ray(KIND_READ, 256, 0, 0, 0);
                send_ray(KIND_READ, 0, -512, 0, 0);
                send_ray(KIND_READ, 511, 511, 511, 511);
                send_ray(KIND_READ, 0, 0, -512, -512);
                send_ray(KIND_READ, 255, 0, 0, 0);
                send_ray(KIND_READ, 255, 255, 0, 0);
                send_ray(KIND_READ, 12, 30, 0, 0);
                send_ray(KIND_READ, 100, 100, 0, 0);
            end
            if (s == 1) begin
                // repeated hits on the same cells drive the stored words to their limits
                repeat (6) send_ray(KIND_RAY, 4, 4, 4, 4);
                repeat (6) send_ray(KIND_RAY, 0, 0, 16, 8);
                send_ray(KIND_READ, 4, 4, 0, 0);
                send_ray(KIND_READ, 0, 0, 0, 0);
            end
            for (int n = 0; n < item_count[s]; n++) begin
                if (s == 2 && n == 100) begin
                    push = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                send_random();
            end
        end

        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (1000) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("occupancy_grid_ray_update_tb: PASS");
        else
            $display("occupancy_grid_ray_update_tb: FAIL");
        $finish;
    end

endmodule

// File: occupancy_grid_ray_update.f
+incdir+sv
sv/ogru_pkg.sv
sv/ogru_front.sv
sv/ogru_back.sv
sv/occupancy_grid_ray_update.sv
verif/occupancy_grid_ray_update_checker.sv
verif/occupancy_grid_ray_update_tb.sv
